/* rtl/ibcm_pkg.sv */
// Package for the int8 broadcast channel multiply block.
// Holds field widths, register indexes, item kinds and the pipeline tag type.
// No dependencies.
`default_nettype none

package ibcm_pkg;

    localparam int MaxChannels = 256;
    localparam int ChAddrW     = $clog2(MaxChannels);
    localparam int CountW      = 9;
    localparam int IndexW      = 8;
    localparam int ValueW      = 8;
    localparam int OpW         = 10;
    localparam int ProdW       = 2 * OpW;
    localparam int ShiftW      = 6;
    localparam int LeftW       = ShiftW - 1;
    localparam int ShW         = ProdW + (1 << LeftW) - 1;
    localparam int MultW       = 31;
    localparam int AccW        = 32;
    localparam int FullW       = 2 * AccW;
    localparam int QW          = AccW + 1;
    localparam int SumW        = QW + 1;
    localparam int NumStages   = 6;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 31;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FIRST_OFFSET  = 3'd0,
        REG_SECOND_OFFSET = 3'd1,
        REG_RESULT_OFFSET = 3'd2,
        REG_CLAMP_LOW     = 3'd3,
        REG_CLAMP_HIGH    = 3'd4,
        REG_SCALE_SHIFT   = 3'd5,
        REG_SCALE_MULT    = 3'd6,
        REG_CHANNEL_COUNT = 3'd7
    } reg_idx_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_ACT  = 1'b1
    } kind_t;

    typedef struct packed {
        logic valid;
        logic pixel_end;
        logic tensor_end;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/ibcm_item_if.sv */
// Input channel of the broadcast channel multiply block: valid, ready and one item.
// Depends on ibcm_pkg.
`default_nettype none

interface ibcm_item_if;
    import ibcm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [IndexW-1:0]        channel_index;
    logic signed [ValueW-1:0] value;
    logic                     last_item;

    modport source (output valid, output kind, output channel_index, output value,
                    output last_item, input ready);
    modport sink   (input valid, input kind, input channel_index, input value,
                    input last_item, output ready);
endinterface

`default_nettype wire

/* rtl/ibcm_result_if.sv */
// Output channel of the broadcast channel multiply block: valid, ready and one result.
// Depends on ibcm_pkg.
`default_nettype none

interface ibcm_result_if;
    import ibcm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ValueW-1:0] product;
    logic                     pixel_end;
    logic                     tensor_end;

    modport source (output valid, output product, output pixel_end, output tensor_end,
                    input ready);
    modport sink   (input valid, input product, input pixel_end, input tensor_end,
                    output ready);
endinterface

`default_nettype wire

/* rtl/ibcm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module ibcm_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/int8_broadcast_channel_multiply_unit.sv */
// Top level of the int8 broadcast channel multiply block.
// Depends on ibcm_pkg, ibcm_item_if, ibcm_result_if and ibcm_ram.
//
// Usage:
// - items (sink): a load beat (kind 0) writes value into the channel vector at
//   channel_index and restarts the channel counter; it gives no result.
//   An activation beat (kind 1) is multiplied by the vector entry at the channel
//   counter and gives exactly one result beat on results.
// - results (source): clamped int8 product, pixel_end on the last channel of a
//   pixel, tensor_end copied from last_item.
// - cfg_write_en/cfg_index/cfg_data: register write, taken at any edge with
//   cfg_write_en high; write only while no activation is in flight.
// Throughput: one beat per cycle while results are not held. Stages: vector
// read, product, shift and saturate, Q31 multiply, rounding high half, rounding
// shift, and offset and clamp, each registered in turn for an accepted activation.
// Stall: all stages advance together; items.ready drops while results are held
// by the receiver, so nothing is lost and the pipeline keeps its contents.
// Reset: registers take their reset values, channel counter returns to zero and
// the pipeline empties; the channel vector is not cleared and must be loaded.
`default_nettype none

module int8_broadcast_channel_multiply_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [ibcm_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [ibcm_pkg::CfgDataW-1:0] cfg_data,
    ibcm_item_if.sink                          items,
    ibcm_result_if.source                      results
);
    import ibcm_pkg::*;

    localparam logic signed [FullW-1:0] NudgePos = FullW'(64'sd1073741824);
    localparam logic signed [FullW-1:0] NudgeNeg = FullW'(-64'sd1073741823);
    localparam logic [CountW-1:0]       CountMax = CountW'(MaxChannels);
    localparam logic [IndexW:0]         IndexLim = (IndexW + 1)'(MaxChannels);

    logic signed [8:0]        first_offset_reg;
    logic signed [8:0]        second_offset_reg;
    logic signed [7:0]        result_offset_reg;
    logic signed [7:0]        clamp_low_reg;
    logic signed [7:0]        clamp_high_reg;
    logic signed [ShiftW-1:0] scale_shift_reg;
    logic [MultW-1:0]         scale_mult_reg;
    logic [CountW-1:0]        channel_count_reg;

    logic [ChAddrW-1:0]       ch_reg;
    logic [ChAddrW-1:0]       ch_next;
    logic [CountW-1:0]        count_eff;
    logic [CountW-1:0]        ch_plus;
    logic                     pend;

    logic                     advance;
    logic                     accept;
    logic                     act_accept;
    logic                     load_write;
    logic [ValueW-1:0]        vec_rdata;

    tag_t                     tag_reg [NumStages];
    logic signed [ValueW-1:0] s1_value_reg;
    logic signed [ProdW-1:0]  s2_prod_reg;
    logic signed [ProdW-1:0]  s2_prod_next;
    logic signed [AccW-1:0]   s3_v_reg;
    logic signed [AccW-1:0]   s3_v_next;
    logic signed [FullW-1:0]  s4_p_reg;
    logic signed [FullW-1:0]  s4_p_next;
    logic signed [AccW-1:0]   s5_v_reg;
    logic signed [AccW-1:0]   s5_v_next;
    logic signed [QW-1:0]     s6_q_reg;
    logic signed [QW-1:0]     s6_q_next;
    logic                     out_valid_reg;
    logic signed [ValueW-1:0] out_product_reg;
    logic signed [ValueW-1:0] out_product_next;
    logic                     out_pixel_end_reg;
    logic                     out_tensor_end_reg;

    logic [LeftW-1:0]         left_amt;
    logic [ShiftW-1:0]        right_amt;

    assign advance    = !out_valid_reg || results.ready;
    assign items.ready = advance;
    assign accept     = items.valid && advance;
    assign act_accept = accept && (items.kind == KIND_ACT);
    assign load_write = accept && (items.kind == KIND_LOAD)
                        && ({1'b0, items.channel_index} < IndexLim);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_offset_reg  <= '0;
            second_offset_reg <= '0;
            result_offset_reg <= '0;
            clamp_low_reg     <= -8'sd128;
            clamp_high_reg    <= 8'sd127;
            scale_shift_reg   <= '0;
            scale_mult_reg    <= 31'd1073741824;
            channel_count_reg <= 9'd1;
        end
        else if (cfg_write_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FIRST_OFFSET:  first_offset_reg  <= cfg_data[8:0];
                REG_SECOND_OFFSET: second_offset_reg <= cfg_data[8:0];
                REG_RESULT_OFFSET: result_offset_reg <= cfg_data[7:0];
                REG_CLAMP_LOW:     clamp_low_reg     <= cfg_data[7:0];
                REG_CLAMP_HIGH:    clamp_high_reg    <= cfg_data[7:0];
                REG_SCALE_SHIFT:   scale_shift_reg   <= cfg_data[ShiftW-1:0];
                REG_SCALE_MULT:    scale_mult_reg    <= cfg_data[MultW-1:0];
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CountW-1:0];
                default:           first_offset_reg  <= first_offset_reg;
            endcase
        end
    end

    // Channel counter
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            count_eff = CountW'(1);
        end
        else if (channel_count_reg > CountMax)
        begin
            count_eff = CountMax;
        end
        else
        begin
            count_eff = channel_count_reg;
        end
        ch_plus = CountW'(ch_reg) + CountW'(1);
        pend    = (ch_plus >= count_eff);
        ch_next = ch_reg;
        if (accept)
        begin
            if (items.kind == KIND_LOAD || pend || items.last_item)
            begin
                ch_next = '0;
            end
            else
            begin
                ch_next = ch_plus[ChAddrW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg <= '0;
        end
        else
        begin
            ch_reg <= ch_next;
        end
    end

    ibcm_ram #(
        .Width (ValueW),
        .Depth (MaxChannels)
    ) u_vec_ram (
        .clk   (clk),
        .we    (load_write),
        .waddr (items.channel_index[ChAddrW-1:0]),
        .wdata (items.value),
        .re    (act_accept),
        .raddr (ch_reg),
        .rdata (vec_rdata)
    );

    // Datapath
    always_comb
    begin
        logic signed [OpW-1:0]   a_op;
        logic signed [OpW-1:0]   b_op;
        logic signed [ShW-1:0]   sh;
        logic signed [FullW-1:0] pn;
        logic signed [AccW-1:0]  v0;
        logic signed [QW-1:0]    v33;
        logic signed [QW-1:0]    q;
        logic [QW-1:0]           mask;
        logic [QW-1:0]           rem;
        logic [QW-1:0]           thr;
        logic signed [SumW-1:0]  r;

        left_amt  = (!scale_shift_reg[ShiftW-1]) ? scale_shift_reg[LeftW-1:0] : '0;
        right_amt = scale_shift_reg[ShiftW-1] ? ShiftW'(-scale_shift_reg) : '0;

        a_op = OpW'(first_offset_reg) + OpW'(s1_value_reg);
        b_op = OpW'(second_offset_reg) + OpW'($signed(vec_rdata));
        s2_prod_next = a_op * b_op;

        sh = ShW'(s2_prod_reg) <<< left_amt;
        if ((&sh[ShW-1:AccW-1]) || !(|sh[ShW-1:AccW-1]))
        begin
            s3_v_next = sh[AccW-1:0];
        end
        else if (sh[ShW-1])
        begin
            s3_v_next = {1'b1, {(AccW-1){1'b0}}};
        end
        else
        begin
            s3_v_next = {1'b0, {(AccW-1){1'b1}}};
        end

        s4_p_next = s3_v_reg * $signed({1'b0, scale_mult_reg});

        pn = s4_p_reg + (s4_p_reg[FullW-1] ? NudgeNeg : NudgePos);
        v0 = AccW'(pn >>> 31);
        s5_v_next = v0 + AccW'(pn[FullW-1] && (|pn[30:0]));

        v33  = QW'(s5_v_reg);
        q    = v33 >>> right_amt;
        mask = (QW'(1) << right_amt) - QW'(1);
        rem  = v33 & mask;
        thr  = (mask >> 1) + QW'(s5_v_reg[AccW-1]);
        s6_q_next = q + QW'(rem > thr);

        r = SumW'(s6_q_reg) + SumW'(result_offset_reg);
        if (r < SumW'(clamp_low_reg))
        begin
            r = SumW'(clamp_low_reg);
        end
        if (r > SumW'(clamp_high_reg))
        begin
            r = SumW'(clamp_high_reg);
        end
        out_product_next = r[ValueW-1:0];
    end

    // Pipeline control: advance all stages together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumStages; i++)
            begin
                tag_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tag_reg[0].valid      <= act_accept;
            tag_reg[0].pixel_end  <= pend;
            tag_reg[0].tensor_end <= items.last_item;
            for (int i = 1; i < NumStages; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            out_valid_reg <= tag_reg[NumStages-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_value_reg       <= items.value;
            s2_prod_reg        <= s2_prod_next;
            s3_v_reg           <= s3_v_next;
            s4_p_reg           <= s4_p_next;
            s5_v_reg           <= s5_v_next;
            s6_q_reg           <= s6_q_next;
            out_product_reg    <= out_product_next;
            out_pixel_end_reg  <= tag_reg[NumStages-1].pixel_end;
            out_tensor_end_reg <= tag_reg[NumStages-1].tensor_end;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.product    = out_product_reg;
    assign results.pixel_end  = out_pixel_end_reg;
    assign results.tensor_end = out_tensor_end_reg;

`ifndef SYNTH
    a_load_clears_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && items.kind == KIND_LOAD) |=> (ch_reg == '0))
        else $error("channel counter not cleared by load beat");

    a_last_clears_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (act_accept && items.last_item) |=> (ch_reg == '0))
        else $error("channel counter not cleared after tensor end");

    a_stall_holds_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance) |=> $stable(ch_reg))
        else $error("channel counter moved while stalled");

    a_tail_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tag_reg[NumStages-1].valid) |=> out_valid_reg)
        else $error("result lost between last stage and output register");
`endif

endmodule

`default_nettype wire
